[src/lagrange_basis_eval_unit_defines.svh]
// Assertion macros for the Lagrange basis evaluator.
// Needs i_clk and i_rst_n in the scope of the module that uses them.
`ifndef LAGRANGE_BASIS_EVAL_UNIT_DEFINES_SVH
`define LAGRANGE_BASIS_EVAL_UNIT_DEFINES_SVH

// same-cycle implication, off while in reset
`define ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off while in reset
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

[src/lbe_pkg.sv]
// Shared constants, types and helper functions of the Lagrange basis evaluator.
// No dependencies; used by every module of the block.
package lbe_pkg;

    localparam int MAX_NODES = 16;
    localparam int FRAC_BITS = 16;
    localparam int X_W       = 24;
    localparam int DATA_W    = 64;
    localparam int HALF_W    = DATA_W / 2;
    localparam int CNT_W     = 5;
    localparam int IDX_W     = 4;
    localparam int NODE_W    = $clog2(MAX_NODES);
    localparam int LANES     = MAX_NODES + 1;
    localparam int CMP_W     = (CNT_W > NODE_W) ? CNT_W : NODE_W + 1;

    // x - (k << F) and its magnitude
    localparam int KSH_W     = NODE_W + FRAC_BITS + 1;
    localparam int DIFF_W    = ((X_W > KSH_W) ? X_W : KSH_W) + 1;
    localparam int PP_W      = HALF_W + DIFF_W;
    localparam int PROD_W    = PP_W + HALF_W + 1;

    localparam int DIV_STEPS = DATA_W;
    // result delay: node stages, slope sum terms, divider entry, steps and exit
    localparam int LATENCY   = 3 * MAX_NODES + DIV_STEPS + 2;

    // configuration register map
    localparam int RIDX_W = 2;
    localparam int ADDR_W = RIDX_W + 2;
    localparam logic [RIDX_W-1:0] REG_NODE_COUNT  = 2'd0;
    localparam logic [RIDX_W-1:0] REG_BASIS_INDEX = 2'd1;
    localparam logic [RIDX_W-1:0] REG_BASIS_MODE  = 2'd2;

    localparam logic [DATA_W-1:0] ONE_Q   = DATA_W'(1) << FRAC_BITS;
    localparam logic [DATA_W-1:0] SAT_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0] SAT_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    typedef struct packed {
        logic [CNT_W-1:0] node_count;
        logic [IDX_W-1:0] basis_index;
        logic             basis_mode;
    } t_cfg;

    // lane 0: full product; lane l: product leaving out node l-1
    typedef logic [LANES-1:0][DATA_W-1:0] t_lanes;
    typedef logic [LANES-1:0]             t_lane_flags;

    // node count clipped to the node capacity
    function automatic logic [CMP_W-1:0] n_eff(t_cfg c);
        logic [CMP_W-1:0] n;
        n = CMP_W'(c.node_count);
        return (n > CMP_W'(MAX_NODES)) ? CMP_W'(MAX_NODES) : n;
    endfunction

    // node takes part in the product (inside the set and not the basis node)
    function automatic logic node_used(t_cfg c, logic [NODE_W-1:0] k);
        return (CMP_W'(k) < n_eff(c)) &&
               !(c.basis_mode && (CMP_W'(k) == CMP_W'(c.basis_index)));
    endfunction

endpackage

[src/lagrange_basis_eval_unit.sv]
// Lagrange basis evaluator top level: register port, node product pipeline,
// slope sum, divider. Depends on lbe_pkg and the assertion macro header.
//
// Use: an item (signed Q8.16 sample) is taken at a clock edge with start high
// and busy low. Each item gives one result: value P(x) and slope P'(x) over
// the integer nodes, both Q48.16 and saturated, plus an overflow flag.
// In basis mode both are divided by the integer denominator.
// The result appears for exactly one cycle with o_strobe high, after the item
// has passed the node stages, the slope sum and the divider. One item per
// cycle is taken while busy is low. The receiver cannot stall the block;
// results are never held back. Reset (synchronous, active low) loads
// node_count 4, basis_index 0, basis_mode 1 and clears the pipeline. After
// reset and after every register write, busy is high while the denominator
// is rebuilt. The user writes the registers over the APB-style port only
// while no item is in flight; the block does not enforce this. node_count is
// at 0x0, basis_index at 0x4, basis_mode at 0x8.
`include "lagrange_basis_eval_unit_defines.svh"

module lagrange_basis_eval_unit import lbe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    input  logic              start,
    output logic              busy,
    input  logic [X_W-1:0]    i_sample_x,
    output logic              o_strobe,
    output logic [DATA_W-1:0] o_poly_value,
    output logic [DATA_W-1:0] o_poly_slope,
    output logic              o_overflow
);

    t_cfg               r_cfg;
    logic               cfg_wr, item_acc;
    logic [RIDX_W-1:0]  reg_idx;
    logic               den_busy, den_neg;
    logic [DATA_W-1:0]  den_mag;
    logic               sum_valid, sum_ov;
    logic [DATA_W-1:0]  sum_value, sum_slope;

    logic [MAX_NODES:0] c_valid;
    logic [X_W-1:0]     c_x  [MAX_NODES];
    t_lanes             c_p  [MAX_NODES+1];
    t_lane_flags        c_ov [MAX_NODES+1];

    // register port
    assign pready   = 1'b1;
    assign reg_idx  = paddr[ADDR_W-1:2];
    assign cfg_wr   = psel & penable & pwrite & pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.node_count  <= CNT_W'(4);
            r_cfg.basis_index <= '0;
            r_cfg.basis_mode  <= 1'b1;
        end else if (cfg_wr) begin
            case (reg_idx)
                REG_NODE_COUNT:  r_cfg.node_count  <= pwdata[CNT_W-1:0];
                REG_BASIS_INDEX: r_cfg.basis_index <= pwdata[IDX_W-1:0];
                REG_BASIS_MODE:  r_cfg.basis_mode  <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_NODE_COUNT:  prdata = 32'(r_cfg.node_count);
            REG_BASIS_INDEX: prdata = 32'(r_cfg.basis_index);
            REG_BASIS_MODE:  prdata = 32'(r_cfg.basis_mode);
            default:         prdata = '0;
        endcase
    end

    // denominator
    lbe_denom u_denom (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cfg     (r_cfg),
        .i_restart (cfg_wr),
        .o_busy    (den_busy),
        .o_dneg    (den_neg),
        .o_dmag    (den_mag)
    );

    assign busy     = den_busy;
    assign item_acc = start & ~busy;

    // product pipeline: every lane starts at 1.0
    assign c_valid[0] = item_acc;
    assign c_x[0]     = i_sample_x;
    assign c_p[0]     = {LANES{ONE_Q}};
    assign c_ov[0]    = '0;

    for (genvar j = 0; j < MAX_NODES; j++) begin : g_node
        if (j < MAX_NODES - 1) begin : g_mid
            lbe_node_stage u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cfg   (r_cfg),
                .i_node  (NODE_W'(j)),
                .i_valid (c_valid[j]),
                .i_x     (c_x[j]),
                .i_p     (c_p[j]),
                .i_ov    (c_ov[j]),
                .o_valid (c_valid[j+1]),
                .o_x     (c_x[j+1]),
                .o_p     (c_p[j+1]),
                .o_ov    (c_ov[j+1])
            );
        end else begin : g_last
            lbe_node_stage u_stage (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_cfg   (r_cfg),
                .i_node  (NODE_W'(j)),
                .i_valid (c_valid[j]),
                .i_x     (c_x[j]),
                .i_p     (c_p[j]),
                .i_ov    (c_ov[j]),
                .o_valid (c_valid[j+1]),
                .o_x     (),
                .o_p     (c_p[j+1]),
                .o_ov    (c_ov[j+1])
            );
        end
    end

    // slope sum
    lbe_slope_sum u_sum (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (r_cfg),
        .i_valid (c_valid[MAX_NODES]),
        .i_p     (c_p[MAX_NODES]),
        .i_ov    (c_ov[MAX_NODES]),
        .o_valid (sum_valid),
        .o_value (sum_value),
        .o_slope (sum_slope),
        .o_ov    (sum_ov)
    );

    // division by the denominator; its output stage drives the result ports
    lbe_div_pipe u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (sum_valid),
        .i_value (sum_value),
        .i_slope (sum_slope),
        .i_ov    (sum_ov),
        .i_dneg  (den_neg),
        .i_dmag  (den_mag),
        .o_valid (o_strobe),
        .o_value (o_poly_value),
        .o_slope (o_poly_slope),
        .o_ov    (o_overflow)
    );

    // checks
    `ASSERT_IMPL(a_result_latency, o_strobe, $past(item_acc, LATENCY), "result without item")
    `ASSERT_IMPL(a_den_ready, sum_valid, !den_busy, "denominator not settled at divider")
    `ASSERT_IMPL(a_den_nonzero, !den_busy, den_mag != '0, "zero denominator")
    `ASSERT_NEXT(a_den_restart, cfg_wr, den_busy, "denominator not rebuilt after write")

endmodule

[src/lbe_node_stage.sv]
// One node of the product pipeline: active lanes multiply by (x - k), two stages.
// Depends on lbe_pkg.
module lbe_node_stage import lbe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic [NODE_W-1:0] i_node,
    input  logic              i_valid,
    input  logic [X_W-1:0]    i_x,
    input  t_lanes            i_p,
    input  t_lane_flags       i_ov,
    output logic              o_valid,
    output logic [X_W-1:0]    o_x,
    output t_lanes            o_p,
    output t_lane_flags       o_ov
);

    logic                         r_va, r_vb;
    logic [X_W-1:0]               r_xa, r_xb;
    t_lanes                       r_pa, r_pb, n_pb;
    t_lane_flags                  r_ova, r_ovb, n_ovb;
    t_lane_flags                  r_act, r_neg, n_act, n_neg;
    logic [LANES-1:0][PP_W-1:0]   r_pp0, r_pp1, n_pp0, n_pp1;
    logic [DIFF_W-1:0]            diff, b_mag;
    logic                         b_neg, used_here;

    // shared factor x - k, as sign and magnitude
    always_comb begin
        used_here = node_used(i_cfg, i_node);
        diff  = DIFF_W'($signed(i_x)) - (DIFF_W'(i_node) << FRAC_BITS);
        b_neg = diff[DIFF_W-1];
        b_mag = b_neg ? (DIFF_W'(0) - diff) : diff;
    end

    // stage A: split the running product into halves and multiply
    always_comb begin
        logic             a_neg;
        logic [DATA_W-1:0] a_mag;
        for (int l = 0; l < LANES; l++) begin
            a_neg     = i_p[l][DATA_W-1];
            a_mag     = a_neg ? (DATA_W'(0) - i_p[l]) : i_p[l];
            n_act[l]  = used_here && ((l == 0) || (i_node != NODE_W'(l - 1)));
            n_neg[l]  = a_neg ^ b_neg;
            n_pp0[l]  = PP_W'(a_mag[HALF_W-1:0]) * PP_W'(b_mag);
            n_pp1[l]  = PP_W'(a_mag[DATA_W-1:HALF_W]) * PP_W'(b_mag);
        end
    end

    // stage B: join halves, drop fraction bits, saturate
    always_comb begin
        logic [PROD_W-1:0] prod, rsh;
        logic              ovf;
        logic [DATA_W-1:0] res;
        for (int l = 0; l < LANES; l++) begin
            prod = (PROD_W'(r_pp1[l]) << HALF_W) + PROD_W'(r_pp0[l]);
            rsh  = prod >> FRAC_BITS;
            ovf  = r_neg[l] ? (rsh > PROD_W'(SAT_NEG)) : (rsh >= PROD_W'(SAT_NEG));
            if (ovf) begin
                res = r_neg[l] ? SAT_NEG : SAT_POS;
            end else begin
                res = r_neg[l] ? (DATA_W'(0) - rsh[DATA_W-1:0]) : rsh[DATA_W-1:0];
            end
            n_pb[l]  = r_act[l] ? res : r_pa[l];
            n_ovb[l] = r_ova[l] | (r_act[l] & ovf);
        end
    end

    // valid bits
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_va <= 1'b0;
            r_vb <= 1'b0;
        end else begin
            r_va <= i_valid;
            r_vb <= r_va;
        end
    end

    // payload
    always_ff @(posedge i_clk) begin
        r_xa  <= i_x;
        r_pa  <= i_p;
        r_ova <= i_ov;
        r_act <= n_act;
        r_neg <= n_neg;
        r_pp0 <= n_pp0;
        r_pp1 <= n_pp1;
        r_xb  <= r_xa;
        r_pb  <= n_pb;
        r_ovb <= n_ovb;
    end

    assign o_valid = r_vb;
    assign o_x     = r_xb;
    assign o_p     = r_pb;
    assign o_ov    = r_ovb;

endmodule

[src/lbe_slope_sum.sv]
// Saturating sum of the leave-one-out products, one term per stage in node order.
// Depends on lbe_pkg.
module lbe_slope_sum import lbe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_valid,
    input  t_lanes            i_p,
    input  t_lane_flags       i_ov,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_value,
    output logic [DATA_W-1:0] o_slope,
    output logic              o_ov
);

    logic [MAX_NODES-1:0]  r_v, n_v, r_ovs, n_ovs;
    t_lanes                r_lanes [MAX_NODES];
    t_lanes                n_lanes [MAX_NODES];
    logic [DATA_W-1:0]     r_sum [MAX_NODES];
    logic [DATA_W-1:0]     n_sum [MAX_NODES];
    logic                  entry_ov;

    // overflow of the value lane and of the lanes that enter the sum
    always_comb begin
        entry_ov = i_ov[0];
        for (int l = 1; l < LANES; l++) begin
            entry_ov = entry_ov | (i_ov[l] & node_used(i_cfg, NODE_W'(l - 1)));
        end
    end

    // stage s adds the product that leaves out node s
    always_comb begin
        logic [DATA_W-1:0] in_sum, term, add;
        logic              in_ov, ovf;
        for (int s = 0; s < MAX_NODES; s++) begin
            if (s == 0) begin
                n_v[s]     = i_valid;
                n_lanes[s] = i_p;
                in_sum     = '0;
                in_ov      = entry_ov;
            end else begin
                n_v[s]     = r_v[s-1];
                n_lanes[s] = r_lanes[s-1];
                in_sum     = r_sum[s-1];
                in_ov      = r_ovs[s-1];
            end
            term = node_used(i_cfg, NODE_W'(s)) ? n_lanes[s][s+1] : '0;
            add  = in_sum + term;
            ovf  = (in_sum[DATA_W-1] == term[DATA_W-1]) &&
                   (add[DATA_W-1] != in_sum[DATA_W-1]);
            n_sum[s] = ovf ? (term[DATA_W-1] ? SAT_NEG : SAT_POS) : add;
            n_ovs[s] = in_ov | ovf;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            r_v <= n_v;
        end
    end

    always_ff @(posedge i_clk) begin
        r_ovs <= n_ovs;
        for (int s = 0; s < MAX_NODES; s++) begin
            r_lanes[s] <= n_lanes[s];
            r_sum[s]   <= n_sum[s];
        end
    end

    assign o_valid = r_v[MAX_NODES-1];
    assign o_value = r_lanes[MAX_NODES-1][0];
    assign o_slope = r_sum[MAX_NODES-1];
    assign o_ov    = r_ovs[MAX_NODES-1];

endmodule

[src/lbe_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage, for value and slope.
// Truncates toward zero; depends on lbe_pkg.
module lbe_div_pipe import lbe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    input  logic [DATA_W-1:0] i_value,
    input  logic [DATA_W-1:0] i_slope,
    input  logic              i_ov,
    input  logic              i_dneg,
    input  logic [DATA_W-1:0] i_dmag,
    output logic              o_valid,
    output logic [DATA_W-1:0] o_value,
    output logic [DATA_W-1:0] o_slope,
    output logic              o_ov
);

    // operand 0 is the value, operand 1 the slope
    logic [DIV_STEPS:0]           r_vld, n_vld, r_ovd, n_ovd;
    logic [1:0]                   r_neg [DIV_STEPS+1];
    logic [1:0]                   n_neg [DIV_STEPS+1];
    logic [1:0][DATA_W-1:0]       r_rem [DIV_STEPS+1];
    logic [1:0][DATA_W-1:0]       n_rem [DIV_STEPS+1];
    logic [1:0][DATA_W-1:0]       r_quo [DIV_STEPS+1];
    logic [1:0][DATA_W-1:0]       n_quo [DIV_STEPS+1];
    logic [1:0][DATA_W-1:0]       num;
    logic [1:0][DATA_W-1:0]       n_res;
    logic [1:0]                   sat;
    logic                         r_out_v;
    logic [DATA_W-1:0]            r_out_val, r_out_slp;
    logic                         r_out_ov;

    assign num = {i_slope, i_value};

    // entry stage to sign and magnitude, then one compare-subtract per stage
    always_comb begin
        logic [DATA_W:0] r2, dif;
        n_vld[0] = i_valid;
        n_ovd[0] = i_ov;
        for (int o = 0; o < 2; o++) begin
            n_neg[0][o] = num[o][DATA_W-1] ^ i_dneg;
            n_rem[0][o] = '0;
            n_quo[0][o] = num[o][DATA_W-1] ? (DATA_W'(0) - num[o]) : num[o];
        end
        for (int s = 1; s <= DIV_STEPS; s++) begin
            n_vld[s] = r_vld[s-1];
            n_ovd[s] = r_ovd[s-1];
            n_neg[s] = r_neg[s-1];
            for (int o = 0; o < 2; o++) begin
                r2  = {r_rem[s-1][o], r_quo[s-1][o][DATA_W-1]};
                dif = r2 - {1'b0, i_dmag};
                if (r2 >= {1'b0, i_dmag}) begin
                    n_rem[s][o] = dif[DATA_W-1:0];
                    n_quo[s][o] = {r_quo[s-1][o][DATA_W-2:0], 1'b1};
                end else begin
                    n_rem[s][o] = r2[DATA_W-1:0];
                    n_quo[s][o] = {r_quo[s-1][o][DATA_W-2:0], 1'b0};
                end
            end
        end
    end

    // exit: apply the sign; a positive quotient of 2^63 saturates
    always_comb begin
        for (int o = 0; o < 2; o++) begin
            sat[o] = !r_neg[DIV_STEPS][o] && (r_quo[DIV_STEPS][o] == SAT_NEG);
            if (sat[o]) begin
                n_res[o] = SAT_POS;
            end else if (r_neg[DIV_STEPS][o]) begin
                n_res[o] = DATA_W'(0) - r_quo[DIV_STEPS][o];
            end else begin
                n_res[o] = r_quo[DIV_STEPS][o];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld   <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_vld   <= n_vld;
            r_out_v <= r_vld[DIV_STEPS];
        end
    end

    always_ff @(posedge i_clk) begin
        r_ovd <= n_ovd;
        for (int s = 0; s <= DIV_STEPS; s++) begin
            r_neg[s] <= n_neg[s];
            r_rem[s] <= n_rem[s];
            r_quo[s] <= n_quo[s];
        end
        r_out_val <= n_res[0];
        r_out_slp <= n_res[1];
        r_out_ov  <= r_ovd[DIV_STEPS] | sat[0] | sat[1];
    end

    assign o_valid = r_out_v;
    assign o_value = r_out_val;
    assign o_slope = r_out_slp;
    assign o_ov    = r_out_ov;

endmodule

[src/lbe_denom.sv]
// Sequential denominator unit: product of (k - i) over nodes k != i, as sign
// and saturated magnitude, rebuilt after reset and every register write.
// Depends on lbe_pkg.
module lbe_denom import lbe_pkg::*; (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cfg              i_cfg,
    input  logic              i_restart,
    output logic              o_busy,
    output logic              o_dneg,
    output logic [DATA_W-1:0] o_dmag
);

    localparam int DP_W = DATA_W + CMP_W;

    logic              r_run, n_run;
    logic [NODE_W-1:0] r_k, n_k;
    logic [DATA_W-1:0] r_mag, n_mag;
    logic              r_neg, n_neg;
    logic [CMP_W-1:0]  kc, ic, fac;
    logic [DP_W-1:0]   prod;

    // one factor per cycle
    always_comb begin
        kc    = CMP_W'(r_k);
        ic    = CMP_W'(i_cfg.basis_index);
        fac   = (kc > ic) ? (kc - ic) : (ic - kc);
        prod  = DP_W'(r_mag) * DP_W'(fac);
        n_run = r_run;
        n_k   = r_k;
        n_mag = r_mag;
        n_neg = r_neg;
        if (i_restart) begin
            n_run = 1'b1;
            n_k   = '0;
            n_mag = DATA_W'(1);
            n_neg = 1'b0;
        end else if (r_run) begin
            if ((kc < n_eff(i_cfg)) && (kc != ic)) begin
                n_mag = (|prod[DP_W-1:DATA_W]) ? {DATA_W{1'b1}} : prod[DATA_W-1:0];
                n_neg = r_neg ^ (kc < ic);
            end
            if (r_k == NODE_W'(MAX_NODES - 1)) begin
                n_run = 1'b0;
            end else begin
                n_k = r_k + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_run <= 1'b1;
            r_k   <= '0;
            r_mag <= DATA_W'(1);
            r_neg <= 1'b0;
        end else begin
            r_run <= n_run;
            r_k   <= n_k;
            r_mag <= n_mag;
            r_neg <= n_neg;
        end
    end

    // full mode divides by one
    assign o_busy = r_run;
    assign o_dneg = i_cfg.basis_mode & r_neg;
    assign o_dmag = i_cfg.basis_mode ? r_mag : DATA_W'(1);

endmodule
